### rtl/dtw_pkg.sv
// shared types and constants of the dtw distance engine
package dtw_pkg;

  // function codes of an input item
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // fixed payload widths of the channels
  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_SQ_W    = 48;
  localparam int OUT_RT_W    = 24;

  // tag that travels with a query sample along the cell chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } dtw_tag_t;

endpackage

### rtl/dtw_in_if.sv
// input channel: reference loads and query samples
interface dtw_in_if;
  import dtw_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [IN_SAMPLE_W-1:0] sample;
  logic                          last;

  modport source (output valid, func, sample, last, input ready);
  modport sink   (input valid, func, sample, last, output ready);
endinterface

### rtl/dtw_out_if.sv
// result channel: warping cost, its square root and status flags
interface dtw_out_if;
  import dtw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OUT_SQ_W-1:0] distance_sq;
  logic [OUT_RT_W-1:0] distance;
  logic                no_path;
  logic                saturated;
  logic                ref_truncated;

  modport source (output valid, distance_sq, distance, no_path, saturated, ref_truncated,
                  input ready);
  modport sink   (input valid, distance_sq, distance, no_path, saturated, ref_truncated,
                  output ready);
endinterface

### rtl/dtw_distance_engine.sv
// dtw distance engine: load and query control, cell chain, square root and result register
// query items and load items are taken one per cycle while not held as below; a query row
// runs down a chain of MAX_REF_LEN cells, one cell per cycle, so rows of one query overlap
// in the chain; the final row cost goes from the chain end register through the square root
// into the result register; a load item waits until the chain has drained, and a final
// query item waits while the previous result has not been taken
// synchronous reset empties the reference and cancels any query; no clearing pass
module dtw_distance_engine #(
  parameter int MAX_REF_LEN  = 256,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  dtw_in_if.sink    in_ch,
  dtw_out_if.source out_ch
);
  import dtw_pkg::*;

  localparam int N     = MAX_REF_LEN;
  localparam int CNT_W = $clog2(N + 1);
  localparam int DR_W  = $clog2(N + 3);
  localparam int RT_W  = (ACC_WIDTH + 1) / 2;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  logic [SAMPLE_WIDTH-1:0] x_raw;
  logic                    in_acc;
  logic                    ld_acc;
  logic                    q_acc;
  logic                    out_acc;
  logic                    busy;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] wr_idx;
  logic             ref_open_r, ref_open_nxt;
  logic             trunc_r, trunc_nxt;
  logic             qact_r, qact_nxt;
  logic [DR_W-1:0]  drain_r;
  logic             pend_r;
  logic             res_np_r;
  logic             res_tr_r;

  dtw_tag_t head_tag;
  dtw_tag_t tail_r;
  logic     tail_fin;

  logic [N-1:0]            ref_we;
  logic [N-1:0]            cell_en;
  dtw_tag_t                tag_a  [N];
  logic [SAMPLE_WIDTH-1:0] x_a    [N];
  dtw_tag_t                tag_b  [N];
  logic [ACC_WIDTH-1:0]    cost   [N];

  logic [ACC_WIDTH-1:0] hold_cost_r;
  logic                 sq_done;
  logic [RT_W-1:0]      sq_root;
  logic [OUT_SQ_W-1:0]  sq_clamp;
  logic [OUT_RT_W-1:0]  rt_clamp;

  logic                out_valid_r;
  logic [OUT_SQ_W-1:0] out_sq_r;
  logic [OUT_RT_W-1:0] out_rt_r;
  logic                out_np_r;
  logic                out_sat_r;
  logic                out_tr_r;

  // low SAMPLE_WIDTH sample bits used, zero-extended when SAMPLE_WIDTH is wider; sign taken from bit SAMPLE_WIDTH-1
  generate
    if (SAMPLE_WIDTH <= IN_SAMPLE_W) begin : g_smp_narrow
      assign x_raw = in_ch.sample[SAMPLE_WIDTH-1:0];
    end else begin : g_smp_wide
      assign x_raw = {{(SAMPLE_WIDTH - IN_SAMPLE_W){1'b0}}, in_ch.sample};
    end
  endgenerate

  // input handshake: loads wait for an empty chain, final samples for a free result slot
  assign busy = (drain_r != '0);
  always_comb begin
    if (in_ch.func == FUNC_LOAD) begin
      in_ch.ready = !busy;
    end else begin
      in_ch.ready = !(in_ch.last && pend_r);
    end
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign ld_acc  = in_acc && (in_ch.func == FUNC_LOAD);
  assign q_acc   = in_acc && (in_ch.func == FUNC_QUERY);
  assign out_acc = out_valid_r && out_ch.ready;

  // reference load and query bookkeeping
  assign wr_idx = ref_open_r ? cnt_r : '0;
  always_comb begin
    cnt_nxt      = cnt_r;
    ref_open_nxt = ref_open_r;
    trunc_nxt    = trunc_r;
    qact_nxt     = qact_r;
    if (ld_acc) begin
      qact_nxt     = 1'b0;
      ref_open_nxt = !in_ch.last;
      trunc_nxt    = ref_open_r ? trunc_r : 1'b0;
      cnt_nxt      = wr_idx;
      if (wr_idx < CNT_W'(N)) begin
        cnt_nxt = wr_idx + CNT_W'(1);
      end else begin
        trunc_nxt = 1'b1;
      end
    end else if (q_acc) begin
      ref_open_nxt = 1'b0;
      qact_nxt     = !in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ref_open_r <= 1'b0;
      trunc_r    <= 1'b0;
      qact_r     <= 1'b0;
      drain_r    <= '0;
      pend_r     <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      ref_open_r <= ref_open_nxt;
      trunc_r    <= trunc_nxt;
      qact_r     <= qact_nxt;
      if (q_acc) begin
        drain_r <= DR_W'(N + 2);
      end else if (busy) begin
        drain_r <= drain_r - DR_W'(1);
      end
      if (q_acc && in_ch.last) begin
        pend_r <= 1'b1;
      end else if (out_acc) begin
        pend_r <= 1'b0;
      end
    end
  end

  // status of the reference as seen by the final query item
  always_ff @(posedge clk) begin
    if (q_acc && in_ch.last) begin
      res_np_r <= (cnt_r == '0);
      res_tr_r <= trunc_r;
    end
  end

  // tag entering the chain with the query sample
  always_comb begin
    head_tag.valid = q_acc;
    head_tag.first = !qact_r;
    head_tag.last  = in_ch.last;
  end

  // chain of cells, one per reference position
  generate
    for (genvar j = 0; j < N; j++) begin : g_cell
      assign ref_we[j]  = ld_acc && (wr_idx == CNT_W'(j));
      assign cell_en[j] = (cnt_r > CNT_W'(j));
      if (j == 0) begin : g_head
        dtw_cell #(
          .SAMPLE_WIDTH (SAMPLE_WIDTH),
          .ACC_WIDTH    (ACC_WIDTH)
        ) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ref_we    (ref_we[j]),
          .ref_data  (x_raw),
          .en        (cell_en[j]),
          .diag_init ('0),
          .tag_in    (head_tag),
          .x_in      (x_raw),
          .left_in   (ACC_MAX),
          .tag_a     (tag_a[j]),
          .x_a       (x_a[j]),
          .tag_b     (tag_b[j]),
          .cost      (cost[j])
        );
      end else begin : g_body
        dtw_cell #(
          .SAMPLE_WIDTH (SAMPLE_WIDTH),
          .ACC_WIDTH    (ACC_WIDTH)
        ) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ref_we    (ref_we[j]),
          .ref_data  (x_raw),
          .en        (cell_en[j]),
          .diag_init (ACC_MAX),
          .tag_in    (tag_a[j-1]),
          .x_in      (x_a[j-1]),
          .left_in   (cost[j-1]),
          .tag_a     (tag_a[j]),
          .x_a       (x_a[j]),
          .tag_b     (tag_b[j]),
          .cost      (cost[j])
        );
      end
    end
  endgenerate

  // chain end: final row cost is ready in the cycle after the last cell's stage b
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= '0;
    end else begin
      tail_r <= tag_b[N-1];
    end
  end
  assign tail_fin = tail_r.valid && tail_r.last;

  always_ff @(posedge clk) begin
    if (tail_fin) begin
      hold_cost_r <= cost[N-1];
    end
  end

  dtw_sqrt #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tail_fin),
    .value (cost[N-1]),
    .done  (sq_done),
    .root  (sq_root)
  );

  // clamp cost and root to the output widths
  generate
    if (ACC_WIDTH > OUT_SQ_W) begin : g_sq_clamp
      assign sq_clamp = (|hold_cost_r[ACC_WIDTH-1:OUT_SQ_W]) ? '1 : hold_cost_r[OUT_SQ_W-1:0];
    end else begin : g_sq_ext
      assign sq_clamp = OUT_SQ_W'(hold_cost_r);
    end
    if (RT_W > OUT_RT_W) begin : g_rt_clamp
      assign rt_clamp = (|sq_root[RT_W-1:OUT_RT_W]) ? '1 : sq_root[OUT_RT_W-1:0];
    end else begin : g_rt_ext
      assign rt_clamp = OUT_RT_W'(sq_root);
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_done) begin
      out_sq_r  <= sq_clamp;
      out_rt_r  <= res_np_r ? '1 : rt_clamp;
      out_np_r  <= res_np_r;
      out_sat_r <= !res_np_r && (hold_cost_r == ACC_MAX);
      out_tr_r  <= res_tr_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.distance_sq   = out_sq_r;
  assign out_ch.distance      = out_rt_r;
  assign out_ch.no_path       = out_np_r;
  assign out_ch.saturated     = out_sat_r;
  assign out_ch.ref_truncated = out_tr_r;

endmodule

### rtl/dtw_cell.sv
// one column of the warping matrix: stored reference sample and running cost
module dtw_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ref_we,
  input  logic [SAMPLE_WIDTH-1:0] ref_data,
  input  logic                    en,
  input  logic [ACC_WIDTH-1:0]    diag_init,
  input  dtw_pkg::dtw_tag_t       tag_in,
  input  logic [SAMPLE_WIDTH-1:0] x_in,
  input  logic [ACC_WIDTH-1:0]    left_in,
  output dtw_pkg::dtw_tag_t       tag_a,
  output logic [SAMPLE_WIDTH-1:0] x_a,
  output dtw_pkg::dtw_tag_t       tag_b,
  output logic [ACC_WIDTH-1:0]    cost
);
  import dtw_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int SUM_W = ((ACC_WIDTH > SQ_W) ? ACC_WIDTH : SQ_W) + 1;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  logic [SAMPLE_WIDTH-1:0] ref_r;
  dtw_tag_t                tag_a_r;
  logic [SAMPLE_WIDTH-1:0] x_a_r;
  dtw_tag_t                tag_b_r;
  logic [SQ_W-1:0]         sq_r;
  logic [ACC_WIDTH-1:0]    cost_r;
  logic [ACC_WIDTH-1:0]    diag_r;

  logic signed [SAMPLE_WIDTH:0] diff;
  logic [SAMPLE_WIDTH:0]        mag_w;
  logic [SAMPLE_WIDTH-1:0]      mag;
  logic [SQ_W-1:0]              sq_nxt;
  logic [ACC_WIDTH-1:0]         up;
  logic [ACC_WIDTH-1:0]         dg;
  logic [ACC_WIDTH-1:0]         best;
  logic [SUM_W-1:0]             sum;
  logic [ACC_WIDTH-1:0]         cell_val;

  // stage a: squared difference of the query sample and the stored sample
  always_comb begin
    diff   = $signed({x_a_r[SAMPLE_WIDTH-1], x_a_r}) - $signed({ref_r[SAMPLE_WIDTH-1], ref_r});
    mag_w  = diff[SAMPLE_WIDTH] ? -diff : diff;
    mag    = mag_w[SAMPLE_WIDTH-1:0];
    sq_nxt = SQ_W'(mag) * SQ_W'(mag);
  end

  // stage b: min of up, left and diagonal plus the square, saturating
  always_comb begin
    up   = tag_b_r.first ? ACC_MAX : cost_r;
    dg   = tag_b_r.first ? diag_init : diag_r;
    best = up;
    if (left_in < best) begin
      best = left_in;
    end
    if (dg < best) begin
      best = dg;
    end
    sum      = SUM_W'(best) + SUM_W'(sq_r);
    cell_val = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_WIDTH-1:0];
  end

  // tags move one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
    end
  end

  // sample store, square and cost registers
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_r <= ref_data;
    end
    x_a_r <= x_in;
    sq_r  <= sq_nxt;
    if (tag_b_r.valid) begin
      if (en) begin
        cost_r <= cell_val;
        diag_r <= left_in;
      end else begin
        // unused column passes the row cost on toward the chain end
        cost_r <= left_in;
      end
    end
  end

  assign tag_a = tag_a_r;
  assign x_a   = x_a_r;
  assign tag_b = tag_b_r;
  assign cost  = cost_r;

endmodule

### rtl/dtw_sqrt.sv
// iterative floor square root, one result bit per cycle
module dtw_sqrt #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ACC_WIDTH-1:0]         value,
  output logic                         done,
  output logic [(ACC_WIDTH+1)/2-1:0]   root
);
  import dtw_pkg::*;

  localparam int RT_W  = (ACC_WIDTH + 1) / 2;
  localparam int RAD_W = 2 * RT_W;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [RT_W:0]    rem_r;
  logic [RT_W-1:0]  root_r;

  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;
  logic [RT_W+1:0]  rem_diff;
  logic [RT_W:0]    rem_nxt;
  logic [RT_W-1:0]  root_nxt;

  // one digit: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_sh   = {rem_r[RT_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    rem_diff = rem_sh - trial;
    if (rem_sh >= trial) begin
      rem_nxt  = rem_diff[RT_W:0];
      root_nxt = {root_r[RT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[RT_W:0];
      root_nxt = {root_r[RT_W-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // radicand, remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(value);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/dtw_checker.sv
// port-level assertions for the dtw distance engine and their binding
module dtw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_func,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dtw_pkg::OUT_SQ_W-1:0]  out_distance_sq,
  input logic [dtw_pkg::OUT_RT_W-1:0]  out_distance,
  input logic                          out_no_path,
  input logic                          out_saturated
);
  import dtw_pkg::*;

  logic [7:0] pend_cnt_r;
  logic       fin_acc;
  logic       out_acc;

  assign fin_acc = in_valid && in_ready && (in_func == FUNC_QUERY) && in_last;
  assign out_acc = out_valid && out_ready;

  // final query items taken whose result has not yet been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= '0;
    end else if (fin_acc && !out_acc) begin
      pend_cnt_r <= pend_cnt_r + 8'd1;
    end else if (out_acc && !fin_acc && (pend_cnt_r != '0)) begin
      pend_cnt_r <= pend_cnt_r - 8'd1;
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_sq) && $stable(out_distance)
      && $stable(out_no_path) && $stable(out_saturated))
    else $error("result changed while stalled");

  // every result answers an earlier final query item
  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_cnt_r != '0)
    else $error("result without a final query item");

  // an empty reference reports infinite cost and no saturation
  a_no_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_path |-> (&out_distance_sq) && (&out_distance) && !out_saturated)
    else $error("no_path result with finite distance");

  // the square of the root never exceeds the cost it was taken from
  a_root_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({24'd0, out_distance} * {24'd0, out_distance}) <= out_distance_sq)
    else $error("distance above square root of distance_sq");

endmodule

bind dtw_distance_engine dtw_checker u_dtw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .in_last         (in_ch.last),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_distance_sq (out_ch.distance_sq),
  .out_distance    (out_ch.distance),
  .out_no_path     (out_ch.no_path),
  .out_saturated   (out_ch.saturated)
);

### tb/sv/dtw_distance_engine_tb.sv
// self-checking testbench of dtw_distance_engine: random and directed series against a row predictor
`timescale 1ns / 1ps

module dtw_distance_engine_tb;
  import dtw_pkg::*;

  localparam int REF_DEPTH   = 256;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 300;
  localparam logic [OUT_SQ_W-1:0] COST_INF = '1;

  typedef struct {
    logic                          fn;
    logic signed [IN_SAMPLE_W-1:0] smp;
    logic                          lst;
  } dtw_item_t;

  typedef struct {
    logic [OUT_SQ_W-1:0] cost_sq;
    logic [OUT_RT_W-1:0] cost_rt;
    logic                no_path;
    logic                sat;
    logic                trunc;
  } dtw_result_t;

  logic clk;
  logic rst_n;

  dtw_in_if  feed_if ();
  dtw_out_if res_if ();

  dtw_distance_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (feed_if),
    .out_ch (res_if)
  );

  // items waiting to be sent and results still owed by the block
  dtw_item_t   feed_q[$];
  dtw_result_t cost_q[$];

  // predictor state: stored reference and the previous matrix row
  logic signed [IN_SAMPLE_W-1:0] ref_mem [REF_DEPTH];
  logic [OUT_SQ_W-1:0]           col_cost[REF_DEPTH];
  logic [OUT_SQ_W-1:0]           corner_cost = COST_INF;
  int                            ref_len     = 0;
  bit                            query_open  = 0;
  bit                            load_open   = 0;
  bit                            dropped     = 0;

  int fails       = 0;
  int fed         = 0;
  int send_idle   = 0;
  int recv_idle   = 0;
  int idle_cycles = 0;
  bit in_taken    = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // floor square root, one result bit per step
  function automatic logic [OUT_RT_W-1:0] root_floor(input logic [OUT_SQ_W-1:0] v);
    logic [OUT_RT_W-1:0] r;
    logic [OUT_RT_W-1:0] t;
    logic [63:0]         sq;
    int                  b;
    r = '0;
    for (b = OUT_RT_W - 1; b >= 0; b--) begin
      t  = r | (24'd1 << b);
      sq = {40'd0, t} * {40'd0, t};
      if (sq <= {16'd0, v}) r = t;
    end
    return r;
  endfunction

  // apply one accepted item to the warping state, queue the cost on a final query sample
  task automatic advance_warp(input logic fn, input logic signed [IN_SAMPLE_W-1:0] x,
                              input logic lst);
    logic signed [17:0]  d;
    logic [17:0]         mag;
    logic [OUT_SQ_W-1:0] sq, left, best, cell_cost, fin_cost;
    logic [OUT_SQ_W:0]   sum;
    dtw_result_t         r;
    bit                  empty;
    int                  j;
    if (fn == FUNC_LOAD) begin
      query_open = 0;
      if (!load_open) begin
        ref_len   = 0;
        dropped   = 0;
        load_open = 1;
      end
      if (ref_len < REF_DEPTH) begin
        ref_mem[ref_len] = x;
        ref_len++;
      end else begin
        dropped = 1;
      end
      if (lst) load_open = 0;
    end else begin
      load_open = 0;
      if (!query_open) begin
        for (j = 0; j < REF_DEPTH; j++) col_cost[j] = COST_INF;
        corner_cost = '0;
        query_open  = 1;
      end
      // one matrix row: min of up, left and diagonal plus squared difference
      left = COST_INF;
      for (j = 0; j < ref_len; j++) begin
        d    = x - ref_mem[j];
        mag  = (d < 0) ? -d : d;
        sq   = mag * mag;
        best = col_cost[j];
        if (left < best) best = left;
        if (corner_cost < best) best = corner_cost;
        sum  = {1'b0, sq} + {1'b0, best};
        cell_cost   = (sum > {1'b0, COST_INF}) ? COST_INF : sum[OUT_SQ_W-1:0];
        corner_cost = col_cost[j];
        col_cost[j] = cell_cost;
        left        = cell_cost;
      end
      corner_cost = COST_INF;
      if (lst) begin
        query_open = 0;
        empty      = (ref_len == 0);
        fin_cost   = empty ? COST_INF : col_cost[ref_len-1];
        r.cost_sq  = fin_cost;
        r.cost_rt  = empty ? '1 : root_floor(fin_cost);
        r.no_path  = empty;
        r.sat      = !empty && (fin_cost == COST_INF);
        r.trunc    = dropped;
        cost_q     = {cost_q, r};
      end
    end
  endtask

  // sample mix: extremes, small values near zero, full range
  function automatic logic signed [IN_SAMPLE_W-1:0] pick_sample();
    logic [IN_SAMPLE_W-1:0] raw;
    raw = IN_SAMPLE_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: raw = 16'h7fff;
          1: raw = 16'h8000;
          2: raw = 16'h0000;
          default: raw = 16'hffff;
        endcase
      end
      1: raw = 16'($urandom_range(0, 255)) - 16'd128;
      default: ;
    endcase
    return raw;
  endfunction

  task automatic queue_item(input logic fn, input logic signed [IN_SAMPLE_W-1:0] x,
                            input logic lst);
    dtw_item_t it;
    it.fn  = fn;
    it.smp = x;
    it.lst = lst;
    feed_q = {feed_q, it};
    fed++;
  endtask

  // a whole series with last on its final sample
  task automatic queue_series(input logic fn, input int len);
    int i;
    for (i = 0; i < len; i++) queue_item(fn, pick_sample(), i == len - 1);
  endtask

  // random mix of loads, queries and broken series
  task automatic queue_random(input int budget);
    int stop, n, i;
    stop = fed + budget;
    // a full or overflowing reference first
    queue_series(FUNC_LOAD, $urandom_range(REF_DEPTH, REF_DEPTH + 6));
    while (fed < stop) begin
      case ($urandom_range(0, 9))
        0: begin
          if ($urandom_range(0, 9) == 0) queue_series(FUNC_LOAD, $urandom_range(200, 262));
          else queue_series(FUNC_LOAD, $urandom_range(1, 16));
        end
        1: begin
          // query cut short by a new reference
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) queue_item(FUNC_QUERY, pick_sample(), 1'b0);
          queue_series(FUNC_LOAD, $urandom_range(1, 8));
        end
        2: begin
          // reference closed early by a query
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) queue_item(FUNC_LOAD, pick_sample(), 1'b0);
          queue_series(FUNC_QUERY, $urandom_range(1, 6));
        end
        default: queue_series(FUNC_QUERY, $urandom_range(1, 8));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || cost_q.size() != 0) @(posedge clk);
  endtask

  // input acceptance: predict, then retire the item
  always @(posedge clk) begin
    if (rst_n && feed_if.valid && feed_if.ready) begin
      advance_warp(feed_if.func, feed_if.sample, feed_if.last);
      void'(feed_q.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // driver: hold an item until taken, idle at random between items
  always @(negedge clk) begin
    if (!rst_n) begin
      feed_if.valid  <= 1'b0;
      feed_if.func   <= FUNC_LOAD;
      feed_if.sample <= '0;
      feed_if.last   <= 1'b0;
    end else if (!feed_if.valid || in_taken) begin
      if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        feed_if.valid  <= 1'b1;
        feed_if.func   <= feed_q[0].fn;
        feed_if.sample <= feed_q[0].smp;
        feed_if.last   <= feed_q[0].lst;
      end else begin
        feed_if.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // result check against the oldest expected cost
  always @(posedge clk) begin : result_check
    dtw_result_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (cost_q.size() == 0) begin
        $error("unexpected result: distance_sq %0h", res_if.distance_sq);
        fails++;
      end else begin
        e = cost_q.pop_front();
        if (res_if.distance_sq !== e.cost_sq) begin
          $error("distance_sq: expected %0h, got %0h", e.cost_sq, res_if.distance_sq);
          fails++;
        end
        if (res_if.distance !== e.cost_rt) begin
          $error("distance: expected %0h, got %0h", e.cost_rt, res_if.distance);
          fails++;
        end
        if (res_if.no_path !== e.no_path) begin
          $error("no_path: expected %0b, got %0b", e.no_path, res_if.no_path);
          fails++;
        end
        if (res_if.saturated !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, res_if.saturated);
          fails++;
        end
        if (res_if.ref_truncated !== e.trunc) begin
          $error("ref_truncated: expected %0b, got %0b", e.trunc, res_if.ref_truncated);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((feed_if.valid && feed_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("dtw_distance_engine test failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    rst_n          = 1'b0;
    feed_if.valid  = 1'b0;
    feed_if.func   = FUNC_LOAD;
    feed_if.sample = '0;
    feed_if.last   = 1'b0;
    res_if.ready   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender rarely idles, receiver mostly stalls
    send_idle = 6;
    recv_idle = 84;

    // queries on an empty reference
    queue_item(FUNC_QUERY, 16'sh7fff, 1'b1);
    queue_item(FUNC_QUERY, 16'sh8000, 1'b0);
    queue_item(FUNC_QUERY, 16'shffff, 1'b1);
    // extreme reference against extreme query
    queue_item(FUNC_LOAD, 16'sh7fff, 1'b0);
    queue_item(FUNC_LOAD, 16'sh8000, 1'b1);
    queue_item(FUNC_QUERY, 16'sh8000, 1'b0);
    queue_item(FUNC_QUERY, 16'sh7fff, 1'b0);
    queue_item(FUNC_QUERY, 16'sh0000, 1'b1);
    // load abandons a running query
    queue_item(FUNC_QUERY, 16'sd5, 1'b0);
    queue_item(FUNC_LOAD, 16'shffff, 1'b1);
    queue_item(FUNC_QUERY, 16'sh0000, 1'b1);
    // query closes an open load
    queue_item(FUNC_LOAD, 16'sd100, 1'b0);
    queue_item(FUNC_LOAD, -16'sd200, 1'b0);
    queue_item(FUNC_QUERY, 16'sd150, 1'b1);
    // alternating bit patterns
    queue_item(FUNC_QUERY, 16'sh5555, 1'b0);
    queue_item(FUNC_QUERY, 16'shaaaa, 1'b1);
    // fresh reference, exact match gives zero cost
    queue_item(FUNC_LOAD, 16'sd7, 1'b1);
    queue_item(FUNC_QUERY, 16'sd7, 1'b1);

    queue_random(333);
    wait_drained();

    // sender mostly idles, receiver rarely stalls
    send_idle = 84;
    recv_idle = 6;
    queue_random(333);
    wait_drained();

    // no idling at all
    send_idle = 0;
    recv_idle = 0;
    queue_random(333);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("dtw_distance_engine test passed");
    end else begin
      $display("dtw_distance_engine test failed");
    end
    $finish;
  end

endmodule

### dtw_distance_engine.f
rtl/dtw_pkg.sv
rtl/dtw_in_if.sv
rtl/dtw_out_if.sv
rtl/dtw_cell.sv
rtl/dtw_sqrt.sv
rtl/dtw_distance_engine.sv
rtl/dtw_checker.sv
tb/sv/dtw_distance_engine_tb.sv
